// ----- hdl/acm_pkg.sv -----
// ----------------------------------------------------------------------------
// ACM selector package
// Shared widths, codes and transaction types of the modcod selector.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

	localparam int IDX_W      = 5;
	localparam int ESN_W      = 16;
	localparam int MARGIN_W   = 13;
	localparam int HOLD_W     = 8;
	localparam int CNT_W      = 32;
	localparam int REASON_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	// threshold + margin + hysteresis never leaves 18 signed bits
	localparam int SUM_W      = 18;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INDEX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INDEX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_HOLD    = 3'd4;

	// change reason codes
	localparam logic [REASON_W-1:0] REASON_NONE = 2'd0;
	localparam logic [REASON_W-1:0] REASON_UP   = 2'd1;
	localparam logic [REASON_W-1:0] REASON_DOWN = 2'd2;
	localparam logic [REASON_W-1:0] REASON_LOCK = 2'd3;

	// item mode codes
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;

	localparam logic [HOLD_W-1:0] STREAK_MAX = 8'd255;

	typedef struct packed {
		logic                    mode;
		logic signed [ESN_W-1:0] esn0;
		logic                    lock;
		logic [IDX_W-1:0]        entry_index;
		logic signed [ESN_W-1:0] entry_threshold;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]    current_index;
		logic [IDX_W-1:0]    previous_index;
		logic [REASON_W-1:0] change_reason;
		logic [CNT_W-1:0]    decision_count;
		logic [CNT_W-1:0]    up_count;
		logic [CNT_W-1:0]    down_count;
	} out_item_t;

	// live configuration with the effective index bounds
	typedef struct packed {
		logic [MARGIN_W-1:0] margin;
		logic [MARGIN_W-1:0] hysteresis;
		logic [HOLD_W-1:0]   up_hold;
		logic [IDX_W-1:0]    lo;
		logic [IDX_W-1:0]    hi;
	} cfg_t;

	// clamp request raised by a register write, with the bounds after it
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} clamp_t;

endpackage

`default_nettype wire

// ----- hdl/acm_cfg.sv -----
// ----------------------------------------------------------------------------
// ACM configuration registers
// Register bank with effective index bounds and a clamp request on write.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_cfg #(
	parameter int NUM_INDICES = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [acm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [acm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output acm_pkg::cfg_t                           cfg,
	output acm_pkg::clamp_t                         clamp
);

	// top allowed index: the table end, capped by the index field width
	localparam int LIM = (NUM_INDICES - 1 > 31) ? 31 : NUM_INDICES - 1;
	localparam logic [acm_pkg::IDX_W-1:0] LIM_IDX = acm_pkg::IDX_W'(LIM);

	logic [acm_pkg::IDX_W-1:0]    min_q, max_q, min_nxt, max_nxt;
	logic [acm_pkg::MARGIN_W-1:0] margin_q, hyst_q;
	logic [acm_pkg::HOLD_W-1:0]   hold_q;
	logic                         hit;

	function automatic logic [acm_pkg::IDX_W-1:0] eff_hi(input logic [acm_pkg::IDX_W-1:0] mx);
		return (mx < LIM_IDX) ? mx : LIM_IDX;
	endfunction

	function automatic logic [acm_pkg::IDX_W-1:0] eff_lo(input logic [acm_pkg::IDX_W-1:0] mn,
			input logic [acm_pkg::IDX_W-1:0] mx);
		logic [acm_pkg::IDX_W-1:0] h;
		h = eff_hi(mx);
		return (mn <= h) ? mn : h;
	endfunction

	always_comb begin
		min_nxt = min_q;
		max_nxt = max_q;
		hit     = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				acm_pkg::CFG_MIN_INDEX: begin
					min_nxt = cfg_data[acm_pkg::IDX_W-1:0];
					hit     = 1'b1;
				end
				acm_pkg::CFG_MAX_INDEX: begin
					max_nxt = cfg_data[acm_pkg::IDX_W-1:0];
					hit     = 1'b1;
				end
				acm_pkg::CFG_MARGIN, acm_pkg::CFG_HYSTERESIS, acm_pkg::CFG_UP_HOLD: begin
					hit = 1'b1;
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= '0;
			max_q    <= 5'd31;
			margin_q <= 13'd256;
			hyst_q   <= 13'd256;
			hold_q   <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acm_pkg::CFG_MIN_INDEX:  min_q    <= cfg_data[acm_pkg::IDX_W-1:0];
				acm_pkg::CFG_MAX_INDEX:  max_q    <= cfg_data[acm_pkg::IDX_W-1:0];
				acm_pkg::CFG_MARGIN:     margin_q <= cfg_data;
				acm_pkg::CFG_HYSTERESIS: hyst_q   <= cfg_data;
				acm_pkg::CFG_UP_HOLD:    hold_q   <= cfg_data[acm_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.margin     = margin_q;
	assign cfg.hysteresis = hyst_q;
	assign cfg.up_hold    = hold_q;
	assign cfg.lo         = eff_lo(min_q, max_q);
	assign cfg.hi         = eff_hi(max_q);

	assign clamp.en = hit;
	assign clamp.lo = eff_lo(min_nxt, max_nxt);
	assign clamp.hi = eff_hi(max_nxt);

endmodule

`default_nettype wire

// ----- hdl/acm_thr_mem.sv -----
// ----------------------------------------------------------------------------
// ACM threshold memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_thr_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [AW-1:0]                       waddr,
	input  wire logic signed [acm_pkg::ESN_W-1:0]    wdata,
	input  wire logic [AW-1:0]                       raddr,
	output logic signed [acm_pkg::ESN_W-1:0]         rdata
);

	logic signed [acm_pkg::ESN_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/acm_cmp.sv -----
// ----------------------------------------------------------------------------
// ACM threshold comparator
// Shared unit: is the estimate at or above threshold plus margin (plus
// hysteresis when stepping up)?
// ----------------------------------------------------------------------------
`default_nettype none

module acm_cmp (
	input  wire logic signed [acm_pkg::ESN_W-1:0]  esn0,
	input  wire logic signed [acm_pkg::ESN_W-1:0]  thr,
	input  wire logic [acm_pkg::MARGIN_W-1:0]      margin,
	input  wire logic [acm_pkg::MARGIN_W-1:0]      hysteresis,
	input  wire logic                              add_hyst,
	output logic                                   ge
);

	logic [acm_pkg::MARGIN_W:0]        addend;
	logic signed [acm_pkg::SUM_W-1:0] bar;

	always_comb begin
		addend = {1'b0, margin} + (add_hyst ? {1'b0, hysteresis} : '0);
		bar    = acm_pkg::SUM_W'(thr) + $signed({4'b0, addend});
		ge     = acm_pkg::SUM_W'(esn0) >= bar;
	end

endmodule

`default_nettype wire

// ----- hdl/acm_modcod_selector.sv -----
// ----------------------------------------------------------------------------
// ACM modcod selector
// Picks a modulation and coding index from Es/N0 estimates against a
// loadable threshold table, with margin, hysteresis and an up-step hold.
// ----------------------------------------------------------------------------
// One transaction is worked at a time; in_ready is high only while the
// sequencer waits for input. A table load or a lock-loss update goes
// straight to the result state; any other update first checks the current
// index, then the next index up, a step-down scan from lo to hi (the
// effective index bounds), or neither when it holds at the ceiling. The
// result state loads the output register and returns to idle for the next
// transaction. The pace is set by the single comparator and the registered
// read data of the threshold memory: the step-down scan reads and compares
// one table entry per cycle. The result sits in an output register, so a new
// transaction is taken while the last result waits for out_ready; a finished
// transaction holds in the result state while the previous result is still
// waiting. Table entries must be loaded before they are used; there is no
// clearing pass.
`default_nettype none

module acm_modcod_selector #(
	parameter int NUM_INDICES = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire acm_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output acm_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_we,
	input  wire logic [acm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [acm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (NUM_INDICES > 1) ? $clog2(NUM_INDICES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_CUR,
		ST_CHK_UP,
		ST_SCAN,
		ST_RESULT
	} state_t;

	state_t                           state_q;
	acm_pkg::in_item_t                item_q;
	logic [acm_pkg::IDX_W-1:0]        cur_q, prev_q, cmp_q, target_q, tgt;
	logic [acm_pkg::HOLD_W-1:0]       streak_q, streak_nxt;
	logic [acm_pkg::CNT_W-1:0]        dec_q, ups_q, downs_q;
	logic [acm_pkg::REASON_W-1:0]     reason_q;
	acm_pkg::out_item_t               out_q;
	logic                             out_valid_q;

	acm_pkg::cfg_t                    cfg;
	acm_pkg::clamp_t                  clamp;

	logic                             accept, mem_we, ge;
	logic [acm_pkg::IDX_W-1:0]        raddr_idx;
	logic signed [acm_pkg::ESN_W-1:0] rdata;

	acm_cfg #(
		.NUM_INDICES(NUM_INDICES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.clamp     (clamp)
	);

	acm_thr_mem #(
		.DEPTH(NUM_INDICES),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(in_data.entry_index)),
		.wdata (in_data.entry_threshold),
		.raddr (AW'(raddr_idx)),
		.rdata (rdata)
	);

	// compare against margin + hysteresis only on the step-up check
	acm_cmp u_cmp (
		.esn0       (item_q.esn0),
		.thr        (rdata),
		.margin     (cfg.margin),
		.hysteresis (cfg.hysteresis),
		.add_hyst   (state_q == ST_CHK_UP),
		.ge         (ge)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	// drop loads aimed past the end of the table
	assign mem_we    = accept && (in_data.mode == acm_pkg::MODE_LOAD)
		&& (32'(in_data.entry_index) < NUM_INDICES);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// read address for the entry compared in the next cycle
	always_comb begin
		unique case (state_q)
			ST_IDLE:    raddr_idx = cur_q;
			ST_CHK_CUR: raddr_idx = ge ? cur_q + 5'd1 : cfg.lo;
			ST_SCAN:    raddr_idx = cmp_q + 5'd1;
			default:    raddr_idx = cur_q;
		endcase
	end

	// highest qualifying index so far, including the entry under compare
	assign tgt        = ge ? cmp_q : target_q;
	assign streak_nxt = (streak_q == acm_pkg::STREAK_MAX) ? streak_q : streak_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			streak_q    <= '0;
			dec_q       <= '0;
			ups_q       <= '0;
			downs_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the result state reloads the output register itself
			if (out_valid_q && out_ready && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end

			// a register write pulls the index into the new bounds
			if (clamp.en) begin
				if (cur_q < clamp.lo) begin
					cur_q <= clamp.lo;
				end else if (cur_q > clamp.hi) begin
					cur_q <= clamp.hi;
				end
				streak_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q   <= in_data;
						prev_q   <= cur_q;
						reason_q <= acm_pkg::REASON_NONE;
						if (in_data.mode == acm_pkg::MODE_LOAD) begin
							state_q <= ST_RESULT;
						end else begin
							dec_q <= dec_q + 32'd1;
							if (!in_data.lock) begin
								// lock lost: fall to the minimum
								if (cur_q != cfg.lo) begin
									cur_q    <= cfg.lo;
									downs_q  <= downs_q + 32'd1;
									reason_q <= acm_pkg::REASON_LOCK;
								end
								streak_q <= '0;
								state_q  <= ST_RESULT;
							end else begin
								state_q <= ST_CHK_CUR;
							end
						end
					end
				end
				ST_CHK_CUR: begin
					if (!ge) begin
						// below the current bar: scan lo..hi for the best index
						cmp_q    <= cfg.lo;
						target_q <= cfg.lo;
						state_q  <= ST_SCAN;
					end else if (cur_q < cfg.hi) begin
						state_q <= ST_CHK_UP;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_CHK_UP: begin
					if (ge) begin
						if (streak_nxt >= cfg.up_hold) begin
							cur_q    <= cur_q + 5'd1;
							streak_q <= '0;
							ups_q    <= ups_q + 32'd1;
							reason_q <= acm_pkg::REASON_UP;
						end else begin
							streak_q <= streak_nxt;
						end
					end else begin
						streak_q <= '0;
					end
					state_q <= ST_RESULT;
				end
				ST_SCAN: begin
					if (cmp_q == cfg.hi) begin
						if (tgt < cur_q) begin
							cur_q    <= tgt;
							downs_q  <= downs_q + 32'd1;
							reason_q <= acm_pkg::REASON_DOWN;
						end
						streak_q <= '0;
						state_q  <= ST_RESULT;
					end else begin
						cmp_q    <= cmp_q + 5'd1;
						target_q <= tgt;
					end
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.current_index  <= cur_q;
						out_q.previous_index <= prev_q;
						out_q.change_reason  <= reason_q;
						out_q.decision_count <= dec_q;
						out_q.up_count       <= ups_q;
						out_q.down_count     <= downs_q;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// a result reports a change exactly when the index moved
	a_reason_matches_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.change_reason == acm_pkg::REASON_NONE)
			== (out_q.current_index == out_q.previous_index)))
		else $error("change reason disagrees with index movement");

	// an up step moves by exactly one index
	a_up_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.change_reason == acm_pkg::REASON_UP)
			|-> (out_q.current_index == out_q.previous_index + 5'd1))
		else $error("up step is not a single index");

	// every accepted update advances the decision counter by one
	a_decision_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.mode == acm_pkg::MODE_UPDATE) |=> (dec_q == $past(dec_q) + 32'd1))
		else $error("decision counter did not advance");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// ACM modcod selector testbench
// Drives link estimates and threshold loads into the selector, predicts every
// decision from a bit-exact model of the index state machine kept alongside,
// and checks each result transaction field by field while both sides of the
// stream idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_IDX       = 32;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 6;
	// room for the longest step-down scan, with some slack on top
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_REPORTS   = 10;
	localparam int SEGMENT_ITEMS = 95;
	localparam int ESN_MIN       = -32768;
	localparam int ESN_MAX       = 32767;
	localparam int MARGIN_MAX    = (1 << acm_pkg::MARGIN_W) - 1;

	// shapes of the random link traffic
	typedef enum int {
		BURST_GOOD,   // at or above the step-up level
		BURST_SHORT,  // just below the step-up level of the next index
		BURST_FALL,   // lands near any entry in bounds; a scan when below the current level
		BURST_EDGE,   // right on the hold boundary of the current index
		BURST_NOISE,  // any estimate at all
		BURST_UNLOCK, // demodulator out of lock
		BURST_LOAD    // rewrite one table entry
	} burst_kind_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	acm_pkg::in_item_t              in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	acm_pkg::out_item_t             out_data;
	logic                           cfg_we    = 1'b0;
	logic [acm_pkg::CFG_IDX_W-1:0]  cfg_index = acm_pkg::CFG_MIN_INDEX;
	logic [acm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// selector state as the hardware should hold it
	logic [acm_pkg::IDX_W-1:0]    sel_index;
	logic [acm_pkg::HOLD_W-1:0]   sel_streak;
	logic [acm_pkg::CNT_W-1:0]    n_decisions;
	logic [acm_pkg::CNT_W-1:0]    n_ups;
	logic [acm_pkg::CNT_W-1:0]    n_downs;
	int                           thr_mem [NUM_IDX];
	logic [acm_pkg::IDX_W-1:0]    reg_min;
	logic [acm_pkg::IDX_W-1:0]    reg_max;
	logic [acm_pkg::MARGIN_W-1:0] reg_margin;
	logic [acm_pkg::MARGIN_W-1:0] reg_hyst;
	logic [acm_pkg::HOLD_W-1:0]   reg_hold;

	acm_pkg::out_item_t expected_results [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	acm_modcod_selector #(
		.NUM_INDICES(NUM_IDX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// Index bounds and decision prediction
	// ------------------------------------------------------------------------

	// the ceiling never passes the last table entry
	function automatic int hi_bound();
		return (reg_max < NUM_IDX) ? int'(reg_max) : NUM_IDX - 1;
	endfunction

	// a floor above the ceiling collapses onto the ceiling
	function automatic int lo_bound();
		return (int'(reg_min) <= hi_bound()) ? int'(reg_min) : hi_bound();
	endfunction

	// Advance the selector by one accepted transaction and return its result.
	function automatic acm_pkg::out_item_t step_selector(acm_pkg::in_item_t item);
		acm_pkg::out_item_t res;
		int                 esn;
		int                 marg;
		int                 hyst;
		int                 lo;
		int                 hi;
		int                 target;
		int                 nxt;
		int                 m;
		res.previous_index = sel_index;
		res.change_reason  = acm_pkg::REASON_NONE;
		esn  = int'($signed(item.esn0));
		marg = int'(reg_margin);
		hyst = int'(reg_hyst);
		lo   = lo_bound();
		hi   = hi_bound();
		if (item.mode == acm_pkg::MODE_LOAD) begin
			// table load: index, streak and counters stay put
			thr_mem[item.entry_index] = int'($signed(item.entry_threshold));
		end else begin
			n_decisions++;
			if (!item.lock) begin
				// lock lost: fall to the floor, counted as a down change
				if (sel_index != lo) begin
					sel_index = acm_pkg::IDX_W'(lo);
					n_downs++;
					res.change_reason = acm_pkg::REASON_LOCK;
				end
				sel_streak = '0;
			end else if (esn < thr_mem[sel_index] + marg) begin
				// below the current level: take the highest entry still met
				target = lo;
				for (m = lo; m <= hi; m++)
					if (thr_mem[m] + marg <= esn)
						target = m;
				if (target < int'(sel_index)) begin
					sel_index = acm_pkg::IDX_W'(target);
					n_downs++;
					res.change_reason = acm_pkg::REASON_DOWN;
				end
				sel_streak = '0;
			end else if (int'(sel_index) < hi) begin
				nxt = int'(sel_index) + 1;
				if (esn >= thr_mem[nxt] + marg + hyst) begin
					if (sel_streak < acm_pkg::STREAK_MAX)
						sel_streak++;
					// a zero hold behaves as one: the streak is at least one here
					if (sel_streak >= reg_hold) begin
						sel_index  = acm_pkg::IDX_W'(nxt);
						sel_streak = '0;
						n_ups++;
						res.change_reason = acm_pkg::REASON_UP;
					end
				end else begin
					sel_streak = '0;
				end
			end
			// at the ceiling a good estimate leaves the streak alone
		end
		res.current_index  = sel_index;
		res.decision_count = n_decisions;
		res.up_count       = n_ups;
		res.down_count     = n_downs;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus primitives
	// ------------------------------------------------------------------------

	// Fields that a mode does not use get random values: the block must ignore them.
	function automatic acm_pkg::in_item_t load_item(int entry, int value);
		acm_pkg::in_item_t it;
		it.mode            = acm_pkg::MODE_LOAD;
		it.esn0            = acm_pkg::ESN_W'($urandom);
		it.lock            = 1'($urandom);
		it.entry_index     = acm_pkg::IDX_W'(entry);
		it.entry_threshold = acm_pkg::ESN_W'(value);
		return it;
	endfunction

	function automatic acm_pkg::in_item_t update_item(int esn, logic lock);
		acm_pkg::in_item_t it;
		it.mode            = acm_pkg::MODE_UPDATE;
		it.esn0            = acm_pkg::ESN_W'(esn);
		it.lock            = lock;
		it.entry_index     = acm_pkg::IDX_W'($urandom);
		it.entry_threshold = acm_pkg::ESN_W'($urandom);
		return it;
	endfunction

	function automatic int clip_esn(int v);
		return (v < ESN_MIN) ? ESN_MIN : (v > ESN_MAX) ? ESN_MAX : v;
	endfunction

	// Write one register while the block is idle; the write clamps the index
	// into the new bounds and clears the good streak.
	task automatic write_reg(input logic [acm_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[acm_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
		acm_pkg::CFG_MIN_INDEX:  reg_min    = value[acm_pkg::IDX_W-1:0];
		acm_pkg::CFG_MAX_INDEX:  reg_max    = value[acm_pkg::IDX_W-1:0];
		acm_pkg::CFG_MARGIN:     reg_margin = value[acm_pkg::MARGIN_W-1:0];
		acm_pkg::CFG_HYSTERESIS: reg_hyst   = value[acm_pkg::MARGIN_W-1:0];
		acm_pkg::CFG_UP_HOLD:    reg_hold   = value[acm_pkg::HOLD_W-1:0];
		default: ;
		endcase
		if (int'(sel_index) < lo_bound())
			sel_index = acm_pkg::IDX_W'(lo_bound());
		if (int'(sel_index) > hi_bound())
			sel_index = acm_pkg::IDX_W'(hi_bound());
		sel_streak = '0;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one transaction and hold it until accepted. Valid is left high on
	// return so back-to-back transactions never drop it within one time step;
	// an idle gap or drain_block lowers it.
	task automatic send_item(input acm_pkg::in_item_t item);
		acm_pkg::out_item_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		res = step_selector(item);
		expected_results.push_back(res);
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver and result checking
	// ------------------------------------------------------------------------

	// stall_pct = 0 keeps ready high throughout
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : check_results
		acm_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				// result transaction with nothing outstanding
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result at cycle %0d: %p", cycle_count, out_data);
			end else begin
				want = expected_results.pop_front();
				if (out_data.current_index  !== want.current_index  ||
				    out_data.previous_index !== want.previous_index ||
				    out_data.change_reason  !== want.change_reason  ||
				    out_data.decision_count !== want.decision_count ||
				    out_data.up_count       !== want.up_count       ||
				    out_data.down_count     !== want.down_count) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display({"wrong result at cycle %0d:",
							" index %0d/%0d prev %0d/%0d reason %0d/%0d",
							" decisions %0d/%0d ups %0d/%0d downs %0d/%0d",
							" (expected/actual)"},
							cycle_count,
							want.current_index, out_data.current_index,
							want.previous_index, out_data.previous_index,
							want.change_reason, out_data.change_reason,
							want.decision_count, out_data.decision_count,
							want.up_count, out_data.up_count,
							want.down_count, out_data.down_count);
				end
			end
		end
	end

	// hard stop for a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("acm_modcod_selector: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Walk the index up and down through a four-entry table with field extremes.
	task automatic test_directed_link();
		send_idle_pct = 0;
		stall_pct     = 0;
		// keep every scan inside the entries loaded below
		write_reg(acm_pkg::CFG_MAX_INDEX, 3);
		send_item(load_item(0, ESN_MIN));
		send_item(load_item(1, 0));
		send_item(load_item(2, 1024));
		send_item(load_item(3, 2048));
		send_item(load_item(NUM_IDX - 1, ESN_MAX));
		// lock loss while already at the floor moves nothing
		send_item(update_item(0, 1'b0));
		// lowest estimate at the floor: scan finds nothing below, hold
		send_item(update_item(ESN_MIN, 1'b1));
		// exactly on the step-up level: third in a row moves to index 1
		repeat (3) send_item(update_item(512, 1'b1));
		// strongest estimate climbs to the ceiling, then sits there
		repeat (7) send_item(update_item(ESN_MAX, 1'b1));
		// weak estimate: scan lands on index 1
		send_item(update_item(300, 1'b1));
		// lock lost from index 1
		send_item(update_item(300, 1'b0));
		drain_block();
	endtask

	// Register writes: clamping, floor above ceiling, zero hold, widest margins.
	task automatic test_register_corners();
		// raising the floor pulls the index up with it
		write_reg(acm_pkg::CFG_MIN_INDEX, 2);
		send_item(update_item(ESN_MAX, 1'b1));
		send_item(update_item(ESN_MIN, 1'b0));
		drain_block();
		// floor above ceiling: both collapse onto the ceiling
		write_reg(acm_pkg::CFG_MIN_INDEX, 3);
		write_reg(acm_pkg::CFG_MAX_INDEX, 1);
		send_item(update_item(ESN_MIN, 1'b1));
		send_item(update_item(ESN_MAX, 1'b0));
		drain_block();
		// no margins and zero hold: each good estimate steps up at once until the ceiling
		write_reg(acm_pkg::CFG_MIN_INDEX, 0);
		write_reg(acm_pkg::CFG_MAX_INDEX, 3);
		write_reg(acm_pkg::CFG_MARGIN, 0);
		write_reg(acm_pkg::CFG_HYSTERESIS, 0);
		write_reg(acm_pkg::CFG_UP_HOLD, 0);
		repeat (3) send_item(update_item(ESN_MAX, 1'b1));
		drain_block();
		// widest margins and the longest hold
		write_reg(acm_pkg::CFG_MARGIN, MARGIN_MAX);
		write_reg(acm_pkg::CFG_HYSTERESIS, MARGIN_MAX);
		write_reg(acm_pkg::CFG_UP_HOLD, int'(acm_pkg::STREAK_MAX));
		send_item(update_item(ESN_MAX, 1'b1));
		send_item(update_item(10000, 1'b1));
		send_item(update_item(ESN_MAX, 1'b1));
		drain_block();
	endtask

	// Random link traffic over a full table, four idling phases, three
	// register settings per phase.
	task automatic test_random_traffic();
		int          idle_plan [4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{20, 20}};
		int          level;
		int          segment;
		int          left;
		int          len;
		int          roll;
		int          jitter;
		int          cur;
		int          nxt;
		int          esn;
		int          entry;
		int          marg;
		int          hyst;
		int          v_min;
		int          v_max;
		int          v_margin;
		int          v_hyst;
		int          v_hold;
		burst_kind_t burst;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_plan[phase][0];
			stall_pct     = idle_plan[phase][1];
			// fresh rising profile over every entry before any wide scan
			level = -12000 + int'($urandom_range(0, 8000));
			for (int e = 0; e < NUM_IDX; e++) begin
				send_item(load_item(e, level));
				level += int'($urandom_range(64, 600));
			end
			for (int seg = 0; seg < 3; seg++) begin
				segment = phase * 3 + seg;
				drain_block();
				case (segment % 4)
				0: begin
					v_min    = $urandom_range(0, 6);
					v_max    = $urandom_range(24, NUM_IDX - 1);
					v_margin = $urandom_range(0, 1023);
					v_hyst   = $urandom_range(0, 1023);
					v_hold   = $urandom_range(1, 4);
				end
				1: begin
					v_min    = 0;
					v_max    = NUM_IDX - 1;
					v_margin = 0;
					v_hyst   = 0;
					v_hold   = 1;
				end
				2: begin
					v_min    = 0;
					v_max    = NUM_IDX - 1;
					v_margin = MARGIN_MAX;
					v_hyst   = MARGIN_MAX;
					v_hold   = (segment == 2) ? int'(acm_pkg::STREAK_MAX)
						: int'($urandom_range(1, 3));
				end
				default: begin
					// anything the registers hold, floor above ceiling included
					v_min    = $urandom_range(0, NUM_IDX - 1);
					v_max    = $urandom_range(0, NUM_IDX - 1);
					v_margin = $urandom_range(0, MARGIN_MAX);
					v_hyst   = $urandom_range(0, MARGIN_MAX);
					v_hold   = $urandom_range(0, int'(acm_pkg::STREAK_MAX));
				end
				endcase
				write_reg(acm_pkg::CFG_MIN_INDEX, v_min);
				write_reg(acm_pkg::CFG_MAX_INDEX, v_max);
				write_reg(acm_pkg::CFG_MARGIN, v_margin);
				write_reg(acm_pkg::CFG_HYSTERESIS, v_hyst);
				write_reg(acm_pkg::CFG_UP_HOLD, v_hold);
				marg = int'(reg_margin);
				hyst = int'(reg_hyst);
				left = SEGMENT_ITEMS;
				while (left > 0) begin
					roll = $urandom_range(99);
					if (roll < 40)      burst = BURST_GOOD;
					else if (roll < 52) burst = BURST_SHORT;
					else if (roll < 67) burst = BURST_FALL;
					else if (roll < 75) burst = BURST_EDGE;
					else if (roll < 85) burst = BURST_NOISE;
					else if (roll < 91) burst = BURST_UNLOCK;
					else                burst = BURST_LOAD;
					// good runs are longer, so that a short hold count can be reached
					len = (burst == BURST_GOOD) ? $urandom_range(1, 8) : $urandom_range(1, 3);
					for (int k = 0; k < len && left > 0; k++) begin
						// aim at the levels of the index the block holds right now
						cur = int'(sel_index);
						nxt = (cur < hi_bound()) ? cur + 1 : cur;
						case (burst)
						BURST_GOOD: begin
							jitter = $urandom_range(0, 256);
							esn    = clip_esn(thr_mem[nxt] + marg + hyst + jitter);
							send_item(update_item(esn, 1'b1));
						end
						BURST_SHORT: begin
							jitter = $urandom_range(1, 256);
							esn    = clip_esn(thr_mem[nxt] + marg + hyst - jitter);
							send_item(update_item(esn, 1'b1));
						end
						BURST_FALL: begin
							entry  = $urandom_range(lo_bound(), hi_bound());
							jitter = $urandom_range(0, 200);
							esn    = clip_esn(thr_mem[entry] + marg + jitter - 100);
							send_item(update_item(esn, 1'b1));
						end
						BURST_EDGE: begin
							jitter = $urandom_range(0, 8);
							esn    = clip_esn(thr_mem[cur] + marg + jitter - 4);
							send_item(update_item(esn, 1'b1));
						end
						BURST_NOISE: begin
							send_item(update_item(int'($urandom), 1'b1));
						end
						BURST_UNLOCK: begin
							send_item(update_item(int'($urandom), 1'b0));
						end
						default: begin
							// mostly a nudge to an existing entry, now and then any value
							entry = $urandom_range(0, NUM_IDX - 1);
							if ($urandom_range(3) == 0) begin
								send_item(load_item(entry, int'($urandom)));
							end else begin
								jitter = $urandom_range(0, 400);
								send_item(load_item(entry, clip_esn(thr_mem[entry] + jitter - 200)));
							end
						end
						endcase
						left--;
					end
				end
			end
		end
		drain_block();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		// register and state values after reset
		reg_min     = '0;
		reg_max     = acm_pkg::IDX_W'(NUM_IDX - 1);
		reg_margin  = 13'd256;
		reg_hyst    = 13'd256;
		reg_hold    = 8'd3;
		sel_index   = '0;
		sel_streak  = '0;
		n_decisions = '0;
		n_ups       = '0;
		n_downs     = '0;
		foreach (thr_mem[i])
			thr_mem[i] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_link();
		test_register_corners();
		test_random_traffic();
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("acm_modcod_selector: match");
		end else begin
			$display("acm_modcod_selector: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/acm_pkg.sv
hdl/acm_cfg.sv
hdl/acm_thr_mem.sv
hdl/acm_cmp.sv
hdl/acm_modcod_selector.sv
tb/tb.sv
